// ----- hdl/mctp_pkg.sv -----
// ----------------------------------------------------------------------------
// mctp_pkg
// Shared constants for the motor command text parser: field widths, motor
// count and the ASCII codes the tokeniser looks for.
// ----------------------------------------------------------------------------
package mctp_pkg;

	// Number of addressable motors / steppers
	localparam int MOTOR_COUNT = 4;
	localparam int IDX_W       = $clog2(MOTOR_COUNT);

	// Field widths
	localparam int CHAR_W  = 8;
	localparam int ID_W    = 3;
	localparam int VAL_W   = 32;
	localparam int MAG_W   = 31;
	localparam int QMODE_W = 4;

	// Saturation limit of the magnitude accumulator
	localparam logic [MAG_W-1:0] MAG_MAX = '1;

	// ASCII codes
	localparam logic [CHAR_W-1:0] ASCII_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] ASCII_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] ASCII_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] ASCII_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] ASCII_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
	localparam logic [CHAR_W-1:0] ASCII_UP_B  = 8'h42;
	localparam logic [CHAR_W-1:0] ASCII_UP_S  = 8'h53;
	localparam logic [CHAR_W-1:0] ASCII_LO_B  = 8'h62;
	localparam logic [CHAR_W-1:0] ASCII_LO_S  = 8'h73;

	// Command kinds
	localparam logic KIND_MOTOR   = 1'b0;
	localparam logic KIND_STEPPER = 1'b1;

endpackage

// ----- hdl/motor_command_text_parser.sv -----
// ----------------------------------------------------------------------------
// motor_command_text_parser
// Byte-serial parser for motor rpm ('b') and stepper angle ('s') commands,
// each followed by a signed id and a signed value; drops repeated angles.
// ----------------------------------------------------------------------------
// Throughput: one byte per clock while the candidate register can drain; the parser state update is a single pass.
// A result word passes through the candidate register, then the output register,
// before it appears on the outputs.
// Reset: parser returns to idle between tokens, stored last angles and the
// queue mode register clear to zero; no clearing pass is needed.
module motor_command_text_parser (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration write channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [mctp_pkg::QMODE_W-1:0]       cfg_data,
	// byte input channel
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [mctp_pkg::CHAR_W-1:0]        char_in,
	input  logic                               end_of_line,
	// command output channel
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               command_kind,
	output logic [mctp_pkg::ID_W-1:0]          motor_id,
	output logic signed [mctp_pkg::VAL_W-1:0]  command_value,
	output logic                               stop_first
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SKIP,
		PH_NUM_START,
		PH_NUM_SIGN,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		phase_t                       phase;
		logic                         kind;
		logic                         idx;
		logic                         neg;
		logic [mctp_pkg::MAG_W-1:0]   mag;
		logic                         id_ok;
		logic [mctp_pkg::ID_W-1:0]    id;
	} pstate_t;

	typedef struct packed {
		logic                         valid;
		logic                         kind;
		logic [mctp_pkg::ID_W-1:0]    id;
		logic                         neg;
		logic [mctp_pkg::MAG_W-1:0]   mag;
	} emit_t;

	// Id is usable when the parsed number lies in 1..MOTOR_COUNT
	function automatic logic id_in_range(input logic neg, input logic [mctp_pkg::MAG_W-1:0] mag);
		id_in_range = !neg && (mag != '0) &&
			(mag <= mctp_pkg::MAG_W'(mctp_pkg::MOTOR_COUNT));
	endfunction

	// Examine a byte as the possible start of a token
	function automatic pstate_t idle_exam(input pstate_t s, input logic ws, input logic tok,
		input logic tkind);
		pstate_t r;
		r = s;
		if (!ws) begin
			if (tok) begin
				r.kind  = tkind;
				r.idx   = 1'b0;
				r.neg   = 1'b0;
				r.mag   = '0;
				r.phase = PH_NUM_START;
			end else begin
				r.phase = PH_SKIP;
			end
		end
		idle_exam = r;
	endfunction

	pstate_t                          st_q;
	pstate_t                          st_d;
	emit_t                            em_d;
	emit_t                            em_s1;
	logic                             em_v_s1;
	logic [mctp_pkg::QMODE_W-1:0]     qmode_q;
	logic [mctp_pkg::VAL_W-1:0]       last_angle_q [mctp_pkg::MOTOR_COUNT];
	logic                             out_valid_q;
	logic                             kind_q;
	logic [mctp_pkg::ID_W-1:0]        id_q;
	logic [mctp_pkg::VAL_W-1:0]       value_q;
	logic                             stop_q;

	logic                             c_ws, c_dig, c_sign, c_minus, c_tok, c_kind, c_nul;
	logic [3:0]                       c_digit;
	logic [mctp_pkg::MAG_W+3:0]       mag_x10;
	logic [mctp_pkg::MAG_W+3:0]       mag_sum;
	logic [mctp_pkg::MAG_W-1:0]       mag_acc;
	logic                             in_fire;
	logic                             s1_take;
	logic [mctp_pkg::IDX_W-1:0]       angle_idx;
	logic [mctp_pkg::VAL_W-1:0]       cand_val;
	logic                             dup;
	logic [mctp_pkg::IDX_W-1:0]       out_idx;

	// Classify the incoming byte
	always_comb begin
		c_ws    = (char_in == mctp_pkg::ASCII_SPACE) ||
			(char_in inside {[mctp_pkg::ASCII_TAB:mctp_pkg::ASCII_CR]});
		c_dig   = char_in inside {[mctp_pkg::ASCII_ZERO:mctp_pkg::ASCII_NINE]};
		c_minus = (char_in == mctp_pkg::ASCII_MINUS);
		c_sign  = c_minus || (char_in == mctp_pkg::ASCII_PLUS);
		c_kind  = (char_in == mctp_pkg::ASCII_LO_S) || (char_in == mctp_pkg::ASCII_UP_S);
		c_tok   = c_kind || (char_in == mctp_pkg::ASCII_LO_B) ||
			(char_in == mctp_pkg::ASCII_UP_B);
		c_nul   = (char_in == mctp_pkg::ASCII_NUL);
		// low nibble of an ASCII digit is its value
		c_digit = char_in[3:0];
	end

	// Accumulate a decimal digit: mag*10 + d, saturating
	always_comb begin
		mag_x10 = {1'b0, st_q.mag, 3'b000} + {3'b000, st_q.mag, 1'b0};
		mag_sum = mag_x10 + (mctp_pkg::MAG_W+4)'(c_digit);
		if (mag_sum > (mctp_pkg::MAG_W+4)'(mctp_pkg::MAG_MAX)) begin
			mag_acc = mctp_pkg::MAG_MAX;
		end else begin
			mag_acc = mag_sum[mctp_pkg::MAG_W-1:0];
		end
	end

	// Next parser state and emit candidate for one byte
	always_comb begin
		st_d = st_q;
		em_d = '0;
		if (!c_nul) begin
			case (st_q.phase)
				PH_IDLE: begin
					st_d = idle_exam(st_d, c_ws, c_tok, c_kind);
				end
				PH_SKIP: begin
					if (c_ws) begin
						st_d.phase = PH_IDLE;
					end
				end
				PH_NUM_START: begin
					if (c_sign) begin
						st_d.neg   = c_minus;
						st_d.phase = PH_NUM_SIGN;
					end else if (c_dig) begin
						st_d.mag   = mctp_pkg::MAG_W'(c_digit);
						st_d.phase = PH_DIGITS;
					end else if (!c_ws) begin
						// failed number: value 0, then re-examine as token start
						if (st_q.idx) begin
							em_d = '{valid: st_q.id_ok, kind: st_q.kind, id: st_q.id,
								neg: 1'b0, mag: '0};
						end else begin
							st_d.id_ok = 1'b0;
						end
						st_d.idx   = 1'b0;
						st_d.phase = PH_IDLE;
						st_d       = idle_exam(st_d, c_ws, c_tok, c_kind);
					end
				end
				PH_NUM_SIGN: begin
					if (c_dig) begin
						st_d.mag   = mctp_pkg::MAG_W'(c_digit);
						st_d.phase = PH_DIGITS;
					end else begin
						// failed number after a sign: skip the rest of the token
						if (st_q.idx) begin
							em_d = '{valid: st_q.id_ok, kind: st_q.kind, id: st_q.id,
								neg: 1'b0, mag: '0};
						end else begin
							st_d.id_ok = 1'b0;
						end
						st_d.idx   = 1'b0;
						st_d.phase = c_ws ? PH_IDLE : PH_SKIP;
					end
				end
				PH_DIGITS: begin
					if (c_dig) begin
						st_d.mag = mag_acc;
					end else if (!st_q.idx) begin
						// id complete: hold it and start the value
						st_d.id_ok = id_in_range(st_q.neg, st_q.mag);
						st_d.id    = st_q.mag[mctp_pkg::ID_W-1:0];
						st_d.idx   = 1'b1;
						st_d.neg   = 1'b0;
						st_d.mag   = '0;
						st_d.phase = PH_NUM_START;
						if (c_sign) begin
							st_d.neg   = c_minus;
							st_d.phase = PH_NUM_SIGN;
						end else if (!c_ws) begin
							em_d = '{valid: st_d.id_ok, kind: st_q.kind, id: st_d.id,
								neg: 1'b0, mag: '0};
							st_d.idx   = 1'b0;
							st_d.phase = PH_IDLE;
							st_d       = idle_exam(st_d, c_ws, c_tok, c_kind);
						end
					end else begin
						// value complete: issue the command
						em_d = '{valid: st_q.id_ok, kind: st_q.kind, id: st_q.id,
							neg: st_q.neg, mag: st_q.mag};
						st_d.idx   = 1'b0;
						st_d.phase = PH_IDLE;
						st_d       = idle_exam(st_d, c_ws, c_tok, c_kind);
					end
				end
				default: begin
					st_d.phase = PH_IDLE;
				end
			endcase
		end

		// Finish a pending number at end of line
		if (c_nul || end_of_line) begin
			case (st_d.phase)
				PH_DIGITS: begin
					if (!st_d.idx) begin
						st_d.id_ok = id_in_range(st_d.neg, st_d.mag);
						st_d.id    = st_d.mag[mctp_pkg::ID_W-1:0];
						em_d = '{valid: st_d.id_ok, kind: st_d.kind, id: st_d.id,
							neg: 1'b0, mag: '0};
					end else begin
						em_d = '{valid: st_d.id_ok, kind: st_d.kind, id: st_d.id,
							neg: st_d.neg, mag: st_d.mag};
					end
				end
				PH_NUM_START, PH_NUM_SIGN: begin
					if (!st_d.idx) begin
						st_d.id_ok = 1'b0;
					end else begin
						em_d = '{valid: st_d.id_ok, kind: st_d.kind, id: st_d.id,
							neg: 1'b0, mag: '0};
					end
				end
				default: begin
					st_d.phase = PH_IDLE;
				end
			endcase
			st_d.phase = PH_IDLE;
			st_d.idx   = 1'b0;
		end
	end

	// Handshakes: the candidate stage drains into a free output register
	assign cfg_ready = 1'b1;
	assign s1_take   = em_v_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !em_v_s1 || s1_take;
	assign in_fire   = in_valid && in_ready;

	// Output stage: signed value and stepper duplicate check
	always_comb begin
		angle_idx = mctp_pkg::IDX_W'(em_s1.id - mctp_pkg::ID_W'(1));
		if (em_s1.neg) begin
			cand_val = mctp_pkg::VAL_W'(0) - {1'b0, em_s1.mag};
		end else begin
			cand_val = {1'b0, em_s1.mag};
		end
		dup = (em_s1.kind == mctp_pkg::KIND_STEPPER) && (last_angle_q[angle_idx] == cand_val);
	end

	// Hold parser state, stage valids, stored angles and queue mode
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= '{phase: PH_IDLE, kind: 1'b0, idx: 1'b0, neg: 1'b0,
				mag: '0, id_ok: 1'b0, id: '0};
			em_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
			qmode_q     <= '0;
			for (int i = 0; i < mctp_pkg::MOTOR_COUNT; i++) begin
				last_angle_q[i] <= '0;
			end
		end else begin
			if (cfg_valid) begin
				qmode_q <= cfg_data;
			end
			if (in_fire) begin
				st_q    <= st_d;
				em_v_s1 <= em_d.valid;
			end else if (s1_take) begin
				em_v_s1 <= 1'b0;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= s1_take && !dup;
			end
			if (s1_take && !dup && (em_s1.kind == mctp_pkg::KIND_STEPPER)) begin
				last_angle_q[angle_idx] <= cand_val;
			end
		end
	end

	// Advance payload of the candidate and output registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			em_s1 <= em_d;
		end
		if (s1_take) begin
			kind_q  <= em_s1.kind;
			id_q    <= em_s1.id;
			value_q <= cand_val;
			stop_q  <= (em_s1.kind == mctp_pkg::KIND_STEPPER) && !qmode_q[angle_idx];
		end
	end

	assign out_valid     = out_valid_q;
	assign command_kind  = kind_q;
	assign motor_id      = id_q;
	assign command_value = value_q;
	assign stop_first    = stop_q;

	assign out_idx = mctp_pkg::IDX_W'(motor_id - mctp_pkg::ID_W'(1));

	// A motor rpm word never asks to stop first
	a_motor_no_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (command_kind == mctp_pkg::KIND_MOTOR) |-> !stop_first)
		else $error("motor command carries stop_first");

	// Only ids within range reach the output
	a_id_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (motor_id >= mctp_pkg::ID_W'(1)) &&
			(motor_id <= mctp_pkg::ID_W'(mctp_pkg::MOTOR_COUNT)))
		else $error("motor id out of range");

	// An issued stepper angle is the stored last angle of that stepper
	a_angle_stored: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (command_kind == mctp_pkg::KIND_STEPPER) |->
			last_angle_q[out_idx] == command_value)
		else $error("stepper angle not recorded");

	// End of line always leaves the parser idle
	a_eol_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (end_of_line || (char_in == mctp_pkg::ASCII_NUL)) |=>
			st_q.phase == PH_IDLE)
		else $error("parser not idle after end of line");

endmodule

// ----- sim/motor_command_text_parser_test.sv -----
// ----------------------------------------------------------------------------
// motor_command_text_parser_test
// Self-checking bench for the motor command text parser. A byte driver feeds
// command text in bursts; a byte-level predictor tracks the tokeniser,
// number parser and stored angles, and the monitor checks each result word.
// ----------------------------------------------------------------------------
module motor_command_text_parser_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [2:0] {
		LEX_IDLE,
		LEX_SKIP,
		LEX_NUM_START,
		LEX_NUM_SIGN,
		LEX_DIGITS
	} lex_phase_t;

	typedef struct packed {
		logic                          kind;
		logic [mctp_pkg::ID_W-1:0]     id;
		logic [mctp_pkg::VAL_W-1:0]    value;
		logic                          stop;
	} command_t;

	typedef struct packed {
		logic [mctp_pkg::CHAR_W-1:0]   ch;
		logic                          eol;
	} text_byte_t;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [mctp_pkg::QMODE_W-1:0]          cfg_data = '0;
	logic                                  in_valid = 1'b0;
	logic                                  in_ready;
	logic [mctp_pkg::CHAR_W-1:0]           char_in = '0;
	logic                                  end_of_line = 1'b0;
	logic                                  out_valid;
	logic                                  out_ready = 1'b0;
	logic                                  command_kind;
	logic [mctp_pkg::ID_W-1:0]             motor_id;
	logic signed [mctp_pkg::VAL_W-1:0]     command_value;
	logic                                  stop_first;

	motor_command_text_parser uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.char_in       (char_in),
		.end_of_line   (end_of_line),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.command_kind  (command_kind),
		.motor_id      (motor_id),
		.command_value (command_value),
		.stop_first    (stop_first)
	);

	always #5 clk = ~clk;

	// Text still to be sent and commands still to arrive
	text_byte_t pending_text[$];
	command_t   expected_cmds[$];
	int         mismatches = 0;
	int         bytes_queued = 0;
	int         bytes_accepted = 0;
	int         cycle_count = 0;

	// Predictor state
	logic [mctp_pkg::QMODE_W-1:0] model_qmode;
	lex_phase_t                   lex_phase;
	logic                         lex_kind;
	logic                         lex_second;
	logic                         lex_neg;
	logic [mctp_pkg::MAG_W-1:0]   lex_mag;
	logic [mctp_pkg::VAL_W-1:0]   lex_id;
	logic [mctp_pkg::VAL_W-1:0]   angle_mem [mctp_pkg::MOTOR_COUNT];

	// Generator memory of the last angle sent to each stepper
	int                 gen_sign [mctp_pkg::MOTOR_COUNT+1];
	longint unsigned    gen_mag [mctp_pkg::MOTOR_COUNT+1];

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic is_blank(logic [mctp_pkg::CHAR_W-1:0] c);
		return c == mctp_pkg::ASCII_SPACE ||
			(c >= mctp_pkg::ASCII_TAB && c <= mctp_pkg::ASCII_CR);
	endfunction

	function automatic logic is_digit(logic [mctp_pkg::CHAR_W-1:0] c);
		return c >= mctp_pkg::ASCII_ZERO && c <= mctp_pkg::ASCII_NINE;
	endfunction

	// Emit a command for the parsed id, dropping bad ids and repeated angles
	function void issue_command(logic [mctp_pkg::VAL_W-1:0] v);
		command_t cmd;
		int slot;
		if (lex_id < 1 || lex_id > mctp_pkg::MOTOR_COUNT) return;
		slot = int'(lex_id) - 1;
		cmd.kind  = lex_kind;
		cmd.id    = lex_id[mctp_pkg::ID_W-1:0];
		cmd.value = v;
		cmd.stop  = 1'b0;
		if (lex_kind == mctp_pkg::KIND_STEPPER) begin
			if (angle_mem[slot] == v) return;
			angle_mem[slot] = v;
			cmd.stop = !model_qmode[slot];
		end
		expected_cmds.push_back(cmd);
	endfunction

	function void begin_number();
		lex_neg   = 1'b0;
		lex_mag   = '0;
		lex_phase = LEX_NUM_START;
	endfunction

	// Close the current number; a failed id abandons the command
	function void close_number(logic ok);
		logic [mctp_pkg::VAL_W-1:0] v;
		v = '0;
		if (ok) v = lex_neg ? (mctp_pkg::VAL_W'(0) - {1'b0, lex_mag}) : {1'b0, lex_mag};
		if (!lex_second) begin
			if (!ok) begin
				lex_id = '0;
				return;
			end
			lex_id     = v;
			lex_second = 1'b1;
			begin_number();
		end else begin
			lex_second = 1'b0;
			issue_command(v);
		end
	endfunction

	// Finish whatever number is open, as at the end of the string
	function void flush_line();
		for (int g = 0; g < 3; g++) begin
			if (lex_phase == LEX_DIGITS) begin
				close_number(1'b1);
			end else if (lex_phase == LEX_NUM_START || lex_phase == LEX_NUM_SIGN) begin
				close_number(1'b0);
				break;
			end else begin
				break;
			end
			if (lex_phase != LEX_NUM_START) break;
		end
		lex_phase  = LEX_IDLE;
		lex_second = 1'b0;
	endfunction

	function void predict_byte(logic [mctp_pkg::CHAR_W-1:0] c, logic eol);
		logic again;
		logic [34:0] m;
		if (c == mctp_pkg::ASCII_NUL) begin
			flush_line();
			return;
		end
		again = 1'b1;
		for (int g = 0; g < 4 && again; g++) begin
			again = 1'b0;
			case (lex_phase)
				LEX_IDLE: begin
					if (!is_blank(c)) begin
						if (c == mctp_pkg::ASCII_LO_B || c == mctp_pkg::ASCII_UP_B ||
						    c == mctp_pkg::ASCII_LO_S || c == mctp_pkg::ASCII_UP_S) begin
							lex_kind = (c == mctp_pkg::ASCII_LO_S ||
							            c == mctp_pkg::ASCII_UP_S) ?
							           mctp_pkg::KIND_STEPPER : mctp_pkg::KIND_MOTOR;
							lex_second = 1'b0;
							begin_number();
						end else begin
							lex_phase = LEX_SKIP;
						end
					end
				end
				LEX_SKIP: begin
					if (is_blank(c)) lex_phase = LEX_IDLE;
				end
				LEX_NUM_START: begin
					if (!is_blank(c)) begin
						if (c == mctp_pkg::ASCII_MINUS || c == mctp_pkg::ASCII_PLUS) begin
							lex_neg   = (c == mctp_pkg::ASCII_MINUS);
							lex_phase = LEX_NUM_SIGN;
						end else if (is_digit(c)) begin
							lex_mag   = mctp_pkg::MAG_W'(c - mctp_pkg::ASCII_ZERO);
							lex_phase = LEX_DIGITS;
						end else begin
							close_number(1'b0);
							lex_phase = LEX_IDLE;
							again     = 1'b1;
						end
					end
				end
				LEX_NUM_SIGN: begin
					if (is_digit(c)) begin
						lex_mag   = mctp_pkg::MAG_W'(c - mctp_pkg::ASCII_ZERO);
						lex_phase = LEX_DIGITS;
					end else begin
						close_number(1'b0);
						lex_phase = LEX_SKIP;
						again     = 1'b1;
					end
				end
				LEX_DIGITS: begin
					if (is_digit(c)) begin
						m = 35'(lex_mag) * 35'd10 + 35'(c - mctp_pkg::ASCII_ZERO);
						lex_mag = (m > 35'(mctp_pkg::MAG_MAX)) ?
							mctp_pkg::MAG_MAX : m[mctp_pkg::MAG_W-1:0];
					end else begin
						close_number(1'b1);
						if (lex_phase != LEX_NUM_START) lex_phase = LEX_IDLE;
						again = 1'b1;
					end
				end
				default: begin
					lex_phase = LEX_IDLE;
					again     = 1'b1;
				end
			endcase
		end
		if (eol) flush_line();
	endfunction

	// Predict on every accepted byte and check every accepted command word
	always @(posedge clk) begin
		if (!arst_n) begin
			model_qmode = '0;
			lex_phase   = LEX_IDLE;
			lex_kind    = 1'b0;
			lex_second  = 1'b0;
			lex_neg     = 1'b0;
			lex_mag     = '0;
			lex_id      = '0;
			for (int i = 0; i < mctp_pkg::MOTOR_COUNT; i++) angle_mem[i] = '0;
			expected_cmds.delete();
		end else begin
			if (cfg_valid && cfg_ready) model_qmode = cfg_data;
			if (in_valid && in_ready) begin
				predict_byte(char_in, end_of_line);
				bytes_accepted <= bytes_accepted + 1;
			end
			if (out_valid && out_ready) begin
				if (expected_cmds.size() == 0) begin
					report_mismatch($sformatf("unexpected word id %0d value %0d",
					                motor_id, command_value));
				end else begin
					command_t want;
					want = expected_cmds.pop_front();
					if (command_kind !== want.kind)
						report_mismatch($sformatf("kind %0b, want %0b", command_kind,
						                want.kind));
					if (motor_id !== want.id)
						report_mismatch($sformatf("id %0d, want %0d", motor_id, want.id));
					if (command_value !== want.value)
						report_mismatch($sformatf("value %0d, want %0d", command_value,
						                $signed(want.value)));
					if (stop_first !== want.stop)
						report_mismatch($sformatf("stop_first %0b, want %0b", stop_first,
						                want.stop));
				end
			end
		end
	end

	// Byte driver: bursts of random length with random gaps
	int         burst_left = 0;
	int         gap_left = 0;
	text_byte_t next_byte;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid    <= 1'b0;
			char_in     <= '0;
			end_of_line <= 1'b0;
			burst_left  <= 0;
			gap_left    <= 0;
		end else if (!in_valid || in_ready) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (pending_text.size() > 0) begin
				next_byte = pending_text.pop_front();
				in_valid    <= 1'b1;
				char_in     <= next_byte.ch;
				end_of_line <= next_byte.eol;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 48);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: changing stall pattern, plus one long hold-off mid run
	int   stall_mode = 0;
	int   mode_left = 0;
	int   hold_left = 0;
	logic hold_done = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && bytes_accepted >= 250) begin
			out_ready <= 1'b0;
			hold_done <= 1'b1;
			hold_left <= 400;
		end else begin
			if (mode_left == 0) begin
				stall_mode <= $urandom_range(0, 3);
				mode_left  <= $urandom_range(16, 96);
			end else begin
				mode_left <= mode_left - 1;
			end
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= 1'($urandom_range(0, 1));
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Text generation
	task automatic push_char(logic [mctp_pkg::CHAR_W-1:0] c, logic eol);
		text_byte_t b;
		b.ch  = c;
		b.eol = eol;
		pending_text.push_back(b);
		bytes_queued++;
	endtask

	task automatic push_text(string s, logic eol_last);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i], eol_last && i == s.len() - 1);
	endtask

	task automatic push_blank(int n);
		int r;
		repeat (n) begin
			r = $urandom_range(0, 5);
			push_char((r == 5) ? mctp_pkg::ASCII_SPACE :
				mctp_pkg::ASCII_TAB + mctp_pkg::CHAR_W'(r), 1'b0);
		end
	endtask

	// sign: 0 none, 1 plus, 2 minus
	task automatic push_number(int sign, longint unsigned mag);
		if (sign == 1) push_char(mctp_pkg::ASCII_PLUS, 1'b0);
		if (sign == 2) push_char(mctp_pkg::ASCII_MINUS, 1'b0);
		push_text($sformatf("%0d", mag), 1'b0);
	endtask

	function automatic longint unsigned pick_magnitude();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: return 64'($urandom_range(0, 999));
			5, 6: return 64'($urandom_range(0, 99999));
			7: return 64'($urandom);
			8: return $urandom_range(0, 1) ? 64'd2147483647 : 64'd2147483648;
			default: return {$urandom, $urandom} % 64'd1000000000000;
		endcase
	endfunction

	task automatic gen_command();
		logic [mctp_pkg::CHAR_W-1:0] letter;
		int id_val;
		int id_sign;
		int v_sign;
		longint unsigned v_mag;
		case ($urandom_range(0, 3))
			0: letter = mctp_pkg::ASCII_LO_B;
			1: letter = mctp_pkg::ASCII_UP_B;
			2: letter = mctp_pkg::ASCII_LO_S;
			default: letter = mctp_pkg::ASCII_UP_S;
		endcase
		push_char(letter, 1'b0);
		push_blank($urandom_range(0, 2));
		id_sign = ($urandom_range(0, 7) == 0) ? 1 : 0;
		case ($urandom_range(0, 9))
			0: id_val = 0;
			1: id_val = $urandom_range(5, 9);
			2: begin
				id_val  = $urandom_range(1, 4);
				id_sign = 2;
			end
			3: id_val = $urandom_range(10, 300);
			default: id_val = $urandom_range(1, 4);
		endcase
		push_number(id_sign, 64'(id_val));
		// leave the value out now and then; what follows decides the outcome
		if ($urandom_range(0, 9) == 0) return;
		v_sign = $urandom_range(0, 2);
		v_mag  = pick_magnitude();
		if ((letter == mctp_pkg::ASCII_LO_S || letter == mctp_pkg::ASCII_UP_S) &&
		    id_val >= 1 && id_val <= mctp_pkg::MOTOR_COUNT) begin
			// repeat the last angle often enough to exercise the drop
			if ($urandom_range(0, 2) == 0) begin
				v_sign = gen_sign[id_val];
				v_mag  = gen_mag[id_val];
			end
			gen_sign[id_val] = v_sign;
			gen_mag[id_val]  = v_mag;
		end
		push_blank((v_sign != 0) ? $urandom_range(0, 2) : $urandom_range(1, 2));
		push_number(v_sign, v_mag);
	endtask

	task automatic gen_line();
		int n;
		n = $urandom_range(1, 3);
		for (int i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 3) == 0) begin
				// token straight after the previous number
			end else begin
				push_blank($urandom_range(1, 3));
			end
			gen_command();
		end
		case ($urandom_range(0, 3))
			0: pending_text[pending_text.size() - 1].eol = 1'b1;
			1: push_char(mctp_pkg::ASCII_NUL, 1'b0);
			2: push_blank(1);
			default: begin
				push_blank(1);
				pending_text[pending_text.size() - 1].eol = 1'b1;
			end
		endcase
	endtask

	task automatic gen_noise();
		repeat ($urandom_range(1, 4))
			push_char(mctp_pkg::CHAR_W'($urandom_range(0, 255)),
				$urandom_range(0, 15) == 0);
	endtask

	task automatic gen_broken();
		case ($urandom_range(0, 3))
			0: begin
				push_text(" b-", 1'b0);
				push_char(mctp_pkg::CHAR_W'($urandom_range(0, 255)), 1'b0);
			end
			1: push_text(" s1 -q ", 1'b0);
			2: begin
				push_text(" B2 4", 1'b0);
				push_char(mctp_pkg::CHAR_W'($urandom_range(8'h61, 8'h7A)), 1'b0);
			end
			default: push_text(" s+", 1'b1);
		endcase
	endtask

	task automatic random_phase(int count);
		int r;
		while (pending_text.size() < count) begin
			r = $urandom_range(0, 19);
			if (r < 14) gen_line();
			else if (r < 17) gen_noise();
			else gen_broken();
		end
	endtask

	// Hold until every byte is in and every word is out, then let the pipe settle
	task automatic drain();
		do @(posedge clk);
		while (bytes_accepted != bytes_queued || expected_cmds.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_qmode(logic [mctp_pkg::QMODE_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// Sequence of phases
	initial begin
		for (int i = 0; i <= mctp_pkg::MOTOR_COUNT; i++) begin
			gen_sign[i] = 0;
			gen_mag[i]  = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_qmode('0);
		// stepper command with stop first, then a repeat of the reset angle
		push_text("S3 7", 1'b1);
		push_text("s2 +0", 1'b1);
		// id out of range
		push_text("b5 1", 1'b1);
		// sign without digits kills the id; value missing at a zero byte
		push_text("b-x B1 +", 1'b0);
		push_char(mctp_pkg::ASCII_NUL, 1'b0);
		// top byte value with line end, then a sign straight after the id
		push_char(8'hFF, 1'b1);
		push_text("b4-9", 1'b1);
		drain();

		write_qmode('1);
		random_phase(140);
		drain();
		write_qmode(4'b0101);
		random_phase(140);
		drain();
		write_qmode(4'b1010);
		random_phase(140);
		drain();
		write_qmode(4'b0011);
		random_phase(130);
		drain();
		repeat (10) @(posedge clk);

		if (expected_cmds.size() != 0)
			report_mismatch($sformatf("%0d words never arrived", expected_cmds.size()));
		if (mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/mctp_pkg.sv
hdl/motor_command_text_parser.sv
sim/motor_command_text_parser_test.sv
